// File: rtl/ssg_pkg.sv
// Package for the spiral segment generator: shared types and codes.
// No dependencies.
package ssg_pkg;

  typedef logic [9:0] coord_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } seg_t;

  typedef struct packed {
    seg_t seg;
    logic valid;
    logic hit;
    logic fin;
  } res_t;

  typedef struct packed {
    logic start;
    logic advance;
  } spiral_cmd_t;

  typedef enum logic [1:0] {
    FUNC_START   = 2'd0,
    FUNC_ADVANCE = 2'd1,
    FUNC_QUERY   = 2'd2,
    FUNC_POP     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    PH_RIGHT  = 2'd0,
    PH_BOTTOM = 2'd1,
    PH_LEFT   = 2'd2,
    PH_TOP    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP_RD,
    ST_POP_DATA,
    ST_WAIT_OUT
  } state_t;

  localparam logic [2:0] CFG_SCREEN_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_SCREEN_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_FIRST_STEP      = 3'd2;
  localparam logic [2:0] CFG_STEP_GROWTH     = 3'd3;
  localparam logic [2:0] CFG_TOUCH_TOLERANCE = 3'd4;

  localparam logic [10:0] RST_SCREEN_WIDTH    = 11'd240;
  localparam logic [10:0] RST_SCREEN_HEIGHT   = 11'd320;
  localparam logic [7:0]  RST_FIRST_STEP      = 8'd6;
  localparam logic [7:0]  RST_STEP_GROWTH     = 8'd2;
  localparam logic [7:0]  RST_TOUCH_TOLERANCE = 8'd10;

endpackage

// File: rtl/ssg_store.sv
// Edge store: single-port write, single-port registered read memory.
// Depends on ssg_pkg.
module ssg_store import ssg_pkg::*; #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  seg_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output seg_t          rdata
);

  seg_t mem [DEPTH];
  seg_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ssg_hit.sv
// Touch test of one stored edge against a point within a tolerance.
// Depends on ssg_pkg.
module ssg_hit import ssg_pkg::*; (
  input  seg_t       seg,
  input  coord_t     tx,
  input  coord_t     ty,
  input  logic [7:0] tol,
  output logic       near
);

  coord_t      lo;
  coord_t      hi;
  coord_t      d;
  coord_t      p_along;
  coord_t      p_across;
  coord_t      line;
  logic [10:0] p_plus;
  logic [10:0] hi_plus;
  logic        straight;

  always_comb begin
    straight = 1'b1;
    if (seg.y1 == seg.y2) begin
      lo       = (seg.x1 < seg.x2) ? seg.x1 : seg.x2;
      hi       = (seg.x1 < seg.x2) ? seg.x2 : seg.x1;
      line     = seg.y1;
      p_along  = tx;
      p_across = ty;
    end else if (seg.x1 == seg.x2) begin
      lo       = (seg.y1 < seg.y2) ? seg.y1 : seg.y2;
      hi       = (seg.y1 < seg.y2) ? seg.y2 : seg.y1;
      line     = seg.x1;
      p_along  = ty;
      p_across = tx;
    end else begin
      straight = 1'b0;
      lo       = '0;
      hi       = '0;
      line     = '0;
      p_along  = '0;
      p_across = '0;
    end
    d       = (p_across >= line) ? (p_across - line) : (line - p_across);
    p_plus  = {1'b0, p_along} + {3'b000, tol};
    hi_plus = {1'b0, hi} + {3'b000, tol};
    near    = straight && (d <= {2'b00, tol}) && (p_plus >= {1'b0, lo}) &&
              ({1'b0, p_along} <= hi_plus);
  end

endmodule

// File: rtl/ssg_spiral.sv
// Spiral rectangle state: sides, step and phase, and the next edge.
// Depends on ssg_pkg.
module ssg_spiral import ssg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [10:0] screen_width,
  input  logic [10:0] screen_height,
  input  logic [7:0]  first_step,
  input  logic [7:0]  step_growth,
  input  spiral_cmd_t cmd,
  output seg_t        seg,
  output logic        fin
);

  coord_t      left_r, left_nxt;
  coord_t      right_r, right_nxt;
  coord_t      top_r, top_nxt;
  coord_t      bottom_r, bottom_nxt;
  logic [10:0] step_r, step_nxt;
  phase_t      phase_r, phase_nxt;

  logic [10:0] sw_m1, sh_m1;
  coord_t      xm, ym, cx, cy;
  logic [11:0] right_sum, bottom_sum, step_sum;
  coord_t      right_adv, bottom_adv, left_sub, top_sub, left_adv, top_adv;
  logic [10:0] step_adv;

  always_comb begin
    sw_m1 = screen_width - 11'd1;
    sh_m1 = screen_height - 11'd1;
    xm    = (screen_width == '0) ? '0 : (sw_m1[10] ? 10'h3FF : sw_m1[9:0]);
    ym    = (screen_height == '0) ? '0 : (sh_m1[10] ? 10'h3FF : sh_m1[9:0]);
    cx    = (screen_width[10:1] > xm) ? xm : screen_width[10:1];
    cy    = (screen_height[10:1] > ym) ? ym : screen_height[10:1];

    fin = (phase_r == PH_RIGHT) && (left_r == '0) && (right_r >= xm) &&
          (top_r == '0) && (bottom_r >= ym);

    right_sum  = {2'b00, right_r} + {1'b0, step_r};
    bottom_sum = {2'b00, bottom_r} + {1'b0, step_r};
    right_adv  = (right_sum > {2'b00, xm}) ? xm : right_sum[9:0];
    bottom_adv = (bottom_sum > {2'b00, ym}) ? ym : bottom_sum[9:0];
    left_sub   = (step_r >= {1'b0, left_r}) ? '0 : (left_r - step_r[9:0]);
    top_sub    = (step_r >= {1'b0, top_r}) ? '0 : (top_r - step_r[9:0]);
    left_adv   = (left_sub > xm) ? xm : left_sub;
    top_adv    = (top_sub > ym) ? ym : top_sub;
    step_sum   = {1'b0, step_r} + {4'b0000, step_growth};
    step_adv   = step_sum[11] ? 11'h7FF : step_sum[10:0];

    left_nxt   = left_r;
    right_nxt  = right_r;
    top_nxt    = top_r;
    bottom_nxt = bottom_r;
    step_nxt   = step_r;
    phase_nxt  = phase_r;

    unique case (phase_r)
      PH_RIGHT:  seg = '{x1: left_r,  y1: top_r,    x2: right_adv, y2: top_r};
      PH_BOTTOM: seg = '{x1: right_r, y1: top_r,    x2: right_r,   y2: bottom_adv};
      PH_LEFT:   seg = '{x1: right_r, y1: bottom_r, x2: left_adv,  y2: bottom_r};
      PH_TOP:    seg = '{x1: left_r,  y1: bottom_r, x2: left_r,    y2: top_adv};
      default:   seg = '0;
    endcase

    if (cmd.start) begin
      left_nxt   = cx;
      right_nxt  = cx;
      top_nxt    = cy;
      bottom_nxt = cy;
      step_nxt   = {3'b000, first_step};
      phase_nxt  = PH_RIGHT;
    end else if (cmd.advance && !fin) begin
      phase_nxt = phase_t'(phase_r + 2'd1);
      unique case (phase_r)
        PH_RIGHT:  right_nxt  = right_adv;
        PH_BOTTOM: bottom_nxt = bottom_adv;
        PH_LEFT:   left_nxt   = left_adv;
        PH_TOP: begin
          top_nxt  = top_adv;
          step_nxt = step_adv;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      right_r  <= '0;
      top_r    <= '0;
      bottom_r <= '0;
      step_r   <= '0;
      phase_r  <= PH_RIGHT;
    end else begin
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      top_r    <= top_nxt;
      bottom_r <= bottom_nxt;
      step_r   <= step_nxt;
      phase_r  <= phase_nxt;
    end
  end

endmodule

// File: rtl/spiral_segment_generator_hit_test.sv
// Spiral segment generator with edge store and touch hit test.
// Start and advance items: result in the output register in the cycle after accept.
// Pop items: store read, data and output wait states, then the output register; an empty store skips to the wait.
// Touch items: stored edges are scanned one edge per cycle off the store read port,
// stopping early on a hit and skipped with no edges; one item is in flight at a time.
// Reset is synchronous, active low; the store is not cleared, its fill count is.
module spiral_segment_generator_hit_test import ssg_pkg::*; #(
  parameter int STORE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [9:0]  in_touch_x,
  input  logic [9:0]  in_touch_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_seg_x1,
  output logic [9:0]  out_seg_y1,
  output logic [9:0]  out_seg_x2,
  output logic [9:0]  out_seg_y2,
  output logic        out_seg_valid,
  output logic        out_hit,
  output logic        out_finished,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STORE_DEPTH);

  logic [10:0] sw_r, sh_r;
  logic [7:0]  first_r, growth_r, tol_r;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic          chk_r, chk_nxt;
  res_t          pend_r, pend_nxt;
  res_t          out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;
  coord_t        tx_r, tx_nxt, ty_r, ty_nxt;

  func_t         func;
  logic          slot_free;
  logic          acc;
  spiral_cmd_t   cmd;
  seg_t          sp_seg;
  logic          sp_fin;
  logic          mem_we;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] count_m1;
  seg_t          rd_seg;
  logic          near;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r     <= RST_SCREEN_WIDTH;
      sh_r     <= RST_SCREEN_HEIGHT;
      first_r  <= RST_FIRST_STEP;
      growth_r <= RST_STEP_GROWTH;
      tol_r    <= RST_TOUCH_TOLERANCE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:    sw_r     <= cfg_data;
        CFG_SCREEN_HEIGHT:   sh_r     <= cfg_data;
        CFG_FIRST_STEP:      first_r  <= cfg_data[7:0];
        CFG_STEP_GROWTH:     growth_r <= cfg_data[7:0];
        CFG_TOUCH_TOLERANCE: tol_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ssg_spiral u_spiral (
    .clk           (clk),
    .rst_n         (rst_n),
    .screen_width  (sw_r),
    .screen_height (sh_r),
    .first_step    (first_r),
    .step_growth   (growth_r),
    .cmd           (cmd),
    .seg           (sp_seg),
    .fin           (sp_fin)
  );

  ssg_store #(.DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wdata (sp_seg),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_seg)
  );

  ssg_hit u_hit (
    .seg  (rd_seg),
    .tx   (tx_r),
    .ty   (ty_r),
    .tol  (tol_r),
    .near (near)
  );

  // handshake, command and store access
  always_comb begin
    func      = func_t'(in_func);
    slot_free = !out_valid_r || out_ready;
    in_ready  = (state_r == ST_IDLE) &&
                ((func == FUNC_QUERY) || (func == FUNC_POP) || slot_free);
    acc       = in_valid && in_ready;
    cmd.start   = acc && (func == FUNC_START);
    cmd.advance = acc && (func == FUNC_ADVANCE);
    mem_we    = cmd.advance && !sp_fin && (count_r < FULL);
    count_m1  = count_r - CW'(1);
    rd_en     = ((state_r == ST_SCAN) && (scan_r < count_r)) || (state_r == ST_POP_RD);
    rd_addr   = (state_r == ST_POP_RD) ? count_m1[AW-1:0] : scan_r[AW-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && (func == FUNC_QUERY)) begin
          state_nxt = (count_r == '0) ? ST_WAIT_OUT : ST_SCAN;
        end else if (acc && (func == FUNC_POP)) begin
          state_nxt = (count_r == '0) ? ST_WAIT_OUT : ST_POP_RD;
        end
      end
      ST_SCAN: begin
        if (chk_r && (near || (scan_r == count_r))) begin
          state_nxt = ST_WAIT_OUT;
        end
      end
      ST_POP_RD:   state_nxt = ST_POP_DATA;
      ST_POP_DATA: state_nxt = ST_WAIT_OUT;
      ST_WAIT_OUT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    chk_nxt       = 1'b0;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;

    if (cmd.start) begin
      count_nxt = '0;
    end else if (mem_we) begin
      count_nxt = count_r + CW'(1);
    end else if (state_r == ST_POP_RD) begin
      count_nxt = count_m1;
    end

    if (cmd.start) begin
      out_nxt       = '0;
      out_valid_nxt = 1'b1;
    end else if (cmd.advance) begin
      out_nxt       = '0;
      out_valid_nxt = 1'b1;
      if (sp_fin) begin
        out_nxt.fin = 1'b1;
      end else begin
        out_nxt.seg   = sp_seg;
        out_nxt.valid = 1'b1;
      end
    end else if ((state_r == ST_WAIT_OUT) && slot_free) begin
      out_nxt       = pend_r;
      out_valid_nxt = 1'b1;
    end

    if (acc && (func == FUNC_QUERY)) begin
      scan_nxt = '0;
      tx_nxt   = in_touch_x;
      ty_nxt   = in_touch_y;
      pend_nxt = '0;
    end else if (acc && (func == FUNC_POP)) begin
      pend_nxt     = '0;
      pend_nxt.fin = (count_r == '0);
    end else if (state_r == ST_SCAN) begin
      chk_nxt = rd_en;
      if (rd_en) begin
        scan_nxt = scan_r + CW'(1);
      end
      if (chk_r && near) begin
        pend_nxt.hit = 1'b1;
      end
    end else if (state_r == ST_POP_DATA) begin
      pend_nxt.seg   = rd_seg;
      pend_nxt.valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    tx_r   <= tx_nxt;
    ty_r   <= ty_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_seg_x1    = out_r.seg.x1;
  assign out_seg_y1    = out_r.seg.y1;
  assign out_seg_x2    = out_r.seg.x2;
  assign out_seg_y2    = out_r.seg.y2;
  assign out_seg_valid = out_r.valid;
  assign out_hit       = out_r.hit;
  assign out_finished  = out_r.fin;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("fill count above store depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_r <= count_r))
    else $error("scan index past fill count");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP_RD) |=> (count_r == $past(count_m1)))
    else $error("pop did not drop fill count by one");

  a_wait_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_WAIT_OUT) && slot_free) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("pending result not moved to output");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !(cmd.advance || cmd.start))
    else $error("command issued while a multi-cycle item is in flight");
`endif

endmodule

// File: tb/sv/ssg_checker.sv
// Checker for the spiral segment generator: watches the item, result and register
// channels, keeps its own copy of the spiral, edge store and registers, and compares.
// Depends on ssg_pkg for the item codes, register indexes and reset values.
module ssg_checker import ssg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [9:0]  in_touch_x,
  input  logic [9:0]  in_touch_y,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [9:0]  out_seg_x1,
  input  logic [9:0]  out_seg_y1,
  input  logic [9:0]  out_seg_x2,
  input  logic [9:0]  out_seg_y2,
  input  logic        out_seg_valid,
  input  logic        out_hit,
  input  logic        out_finished,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  localparam int DEPTH = 256;

  logic [10:0] scr_w, scr_h;
  logic [7:0]  step0, step_add, tol;
  coord_t      left_x, right_x, top_y, bot_y;
  logic [10:0] step;
  phase_t      phase;
  int          n_edges;
  seg_t        edges [DEPTH];
  res_t        results_due [$];
  res_t        want;

  function automatic int screen_max(logic [10:0] size);
    if (size == 0) return 0;
    return (size - 1 > 1023) ? 1023 : size - 1;
  endfunction

  function automatic res_t spiral_result(func_t f, coord_t tx, coord_t ty);
    int   xm, ym, nxt, t, px, py, ax, ay, bx, by, lo, hi, d;
    seg_t e;
    res_t r;
    r  = '0;
    e  = '0;
    xm = screen_max(scr_w);
    ym = screen_max(scr_h);
    t  = tol;
    px = tx;
    py = ty;
    case (f)
      FUNC_START: begin
        nxt = scr_w / 2;
        left_x  = coord_t'((nxt > xm) ? xm : nxt);
        right_x = left_x;
        nxt = scr_h / 2;
        top_y = coord_t'((nxt > ym) ? ym : nxt);
        bot_y = top_y;
        step    = {3'b000, step0};
        phase   = PH_RIGHT;
        n_edges = 0;
      end
      FUNC_ADVANCE: begin
        if (phase == PH_RIGHT && left_x == 0 && right_x >= xm && top_y == 0 && bot_y >= ym) begin
          r.fin = 1'b1;
          return r;
        end
        case (phase)
          PH_RIGHT: begin
            nxt = right_x + step;
            right_x = coord_t'((nxt > xm) ? xm : nxt);
            e = '{left_x, top_y, right_x, top_y};
          end
          PH_BOTTOM: begin
            nxt = bot_y + step;
            bot_y = coord_t'((nxt > ym) ? ym : nxt);
            e = '{right_x, top_y, right_x, bot_y};
          end
          PH_LEFT: begin
            nxt = (step >= left_x) ? 0 : left_x - step;
            left_x = coord_t'((nxt > xm) ? xm : nxt);
            e = '{right_x, bot_y, left_x, bot_y};
          end
          default: begin
            nxt = (step >= top_y) ? 0 : top_y - step;
            top_y = coord_t'((nxt > ym) ? ym : nxt);
            e = '{left_x, bot_y, left_x, top_y};
            nxt = step + step_add;
            step = 11'((nxt > 2047) ? 2047 : nxt);
          end
        endcase
        phase = phase_t'((int'(phase) + 1) % 4);
        if (n_edges < DEPTH) begin
          edges[n_edges] = e;
          n_edges++;
        end
        r.seg   = e;
        r.valid = 1'b1;
      end
      FUNC_QUERY: begin
        for (int i = 0; i < n_edges && !r.hit; i++) begin
          ax = edges[i].x1;
          ay = edges[i].y1;
          bx = edges[i].x2;
          by = edges[i].y2;
          // a single-point edge counts as horizontal
          if (ay == by) begin
            lo = (ax < bx) ? ax : bx;
            hi = (ax < bx) ? bx : ax;
            d  = (py > ay) ? py - ay : ay - py;
            r.hit = (d <= t && px >= lo - t && px <= hi + t);
          end else if (ax == bx) begin
            lo = (ay < by) ? ay : by;
            hi = (ay < by) ? by : ay;
            d  = (px > ax) ? px - ax : ax - px;
            r.hit = (d <= t && py >= lo - t && py <= hi + t);
          end
        end
      end
      FUNC_POP: begin
        if (n_edges == 0) begin
          r.fin = 1'b1;
        end else begin
          n_edges--;
          r.seg   = edges[n_edges];
          r.valid = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_v);
    if (mismatches < 40)
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, exp_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scr_w    = RST_SCREEN_WIDTH;
      scr_h    = RST_SCREEN_HEIGHT;
      step0    = RST_FIRST_STEP;
      step_add = RST_STEP_GROWTH;
      tol      = RST_TOUCH_TOLERANCE;
      left_x   = '0;
      right_x  = '0;
      top_y    = '0;
      bot_y    = '0;
      step     = '0;
      phase    = PH_RIGHT;
      n_edges  = 0;
      mismatches = 0;
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCREEN_WIDTH:    scr_w    = cfg_data;
          CFG_SCREEN_HEIGHT:   scr_h    = cfg_data;
          CFG_FIRST_STEP:      step0    = cfg_data[7:0];
          CFG_STEP_GROWTH:     step_add = cfg_data[7:0];
          CFG_TOUCH_TOLERANCE: tol      = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = results_due.pop_front();
          if (out_seg_x1 != want.seg.x1) report_mismatch("seg_x1", out_seg_x1, want.seg.x1);
          if (out_seg_y1 != want.seg.y1) report_mismatch("seg_y1", out_seg_y1, want.seg.y1);
          if (out_seg_x2 != want.seg.x2) report_mismatch("seg_x2", out_seg_x2, want.seg.x2);
          if (out_seg_y2 != want.seg.y2) report_mismatch("seg_y2", out_seg_y2, want.seg.y2);
          if (out_seg_valid !== want.valid)
            report_mismatch("seg_valid", out_seg_valid, want.valid);
          if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
          if (out_finished !== want.fin)
            report_mismatch("finished", out_finished, want.fin);
        end
      end
      if (in_valid && in_ready)
        results_due.push_back(spiral_result(func_t'(in_func), in_touch_x, in_touch_y));
    end
    pending = results_due.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the spiral segment generator: clock, reset, item and register
// stimulus, result-side stalls, watchdog and verdict. Depends on ssg_pkg, the block
// and ssg_checker, which predicts and compares.
module tb_top;
  import ssg_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = '0;
  logic [9:0]  in_touch_x = '0;
  logic [9:0]  in_touch_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_seg_x1, out_seg_y1, out_seg_x2, out_seg_y2;
  logic        out_seg_valid, out_hit, out_finished;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  int          mismatches, pending;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  logic [10:0] scr_w = RST_SCREEN_WIDTH;
  logic [10:0] scr_h = RST_SCREEN_HEIGHT;

  spiral_segment_generator_hit_test u_top (.*);
  ssg_checker u_check (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= rcv_idle);

  task automatic send_item(func_t f, logic [9:0] tx, logic [9:0] ty);
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_func    = f;
    in_touch_x = tx;
    in_touch_y = ty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] val);
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(logic [10:0] w, logic [10:0] h, logic [10:0] s0,
                           logic [10:0] g, logic [10:0] t);
    drain();
    cfg_valid = 1'b1;
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    write_reg(CFG_FIRST_STEP, s0);
    write_reg(CFG_STEP_GROWTH, g);
    write_reg(CFG_TOUCH_TOLERANCE, t);
    // unmapped index, must be ignored
    write_reg(3'($urandom_range(CFG_TOUCH_TOLERANCE + 1, 7)), 11'($urandom));
    cfg_valid = 1'b0;
    scr_w = w;
    scr_h = h;
  endtask

  function automatic logic [9:0] touch_coord(logic [10:0] size);
    int lim, mid;
    lim = (size == 0) ? 0 : ((size > 1024) ? 1023 : size - 1);
    mid = size / 2;
    if (mid > lim) mid = lim;
    case ($urandom_range(3))
      0: return 10'($urandom_range(1023));
      1: return 10'($urandom_range(lim));
      default: return 10'($urandom_range((mid < 40) ? 0 : mid - 40,
                                         (mid + 40 > 1023) ? 1023 : mid + 40));
    endcase
  endfunction

  function automatic logic [10:0] pick_size();
    case ($urandom_range(7))
      0: return 11'd2;
      1: return 11'd1024;
      2: return 11'($urandom);
      3: return 11'($urandom_range(3, 64));
      default: return 11'($urandom_range(2, 1024));
    endcase
  endfunction

  function automatic logic [10:0] pick_byte();
    case ($urandom_range(5))
      0: return 11'd0;
      1: return 11'd255;
      2: return 11'($urandom);
      default: return 11'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic run_spiral(int len);
    int r;
    if ($urandom_range(9) != 0) send_item(FUNC_START, 10'($urandom), 10'($urandom));
    repeat (len) begin
      r = $urandom_range(99);
      if (r < 60) send_item(FUNC_ADVANCE, 10'($urandom), 10'($urandom));
      else if (r < 82) send_item(FUNC_QUERY, touch_coord(scr_w), touch_coord(scr_h));
      else if (r < 94) send_item(FUNC_POP, 10'($urandom), 10'($urandom));
      else send_item(func_t'($urandom_range(3)), 10'($urandom), 10'($urandom));
      if ($urandom_range(60) == 0) drain();
    end
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    snd_idle = 29;
    rcv_idle = 77;

    // advance before any start: zero step, single-point edge
    send_item(FUNC_ADVANCE, 10'd0, 10'd0);
    send_item(FUNC_POP, 10'h3ff, 10'h3ff);
    send_item(FUNC_POP, 10'd0, 10'd0);
    send_item(FUNC_QUERY, 10'd0, 10'd0);
    send_item(FUNC_START, 10'd0, 10'd0);
    repeat (8) send_item(FUNC_ADVANCE, 10'h3ff, 10'd0);
    send_item(FUNC_QUERY, 10'd120, 10'd160);
    send_item(FUNC_QUERY, 10'h3ff, 10'h3ff);
    send_item(FUNC_QUERY, 10'd0, 10'h3ff);
    send_item(FUNC_QUERY, 10'd140, 10'd150);
    repeat (2) send_item(FUNC_POP, 10'd0, 10'd0);
    send_item(FUNC_ADVANCE, 10'd0, 10'd0);

    // tiny screen, largest steps: fills the screen after one round
    configure(11'd2, 11'd2, 11'd255, 11'd255, 11'd255);
    send_item(FUNC_START, 10'd0, 10'd0);
    repeat (6) send_item(FUNC_ADVANCE, 10'd0, 10'd0);
    send_item(FUNC_QUERY, 10'd200, 10'd200);
    send_item(FUNC_QUERY, 10'h3ff, 10'h3ff);
    send_item(FUNC_POP, 10'd0, 10'd0);

    // zero width, oversize height, zero step and tolerance
    configure(11'd0, 11'h7ff, 11'd0, 11'd0, 11'd0);
    send_item(FUNC_START, 10'd0, 10'd0);
    repeat (3) send_item(FUNC_ADVANCE, 10'd0, 10'd0);
    send_item(FUNC_QUERY, 10'd0, 10'd1023);
    send_item(FUNC_POP, 10'd0, 10'd0);

    // slow spiral on the largest screen: overflow the store, then pop some
    configure(11'd1024, 11'd1024, 11'd1, 11'd0, 11'd0);
    send_item(FUNC_START, 10'd0, 10'd0);
    repeat (262) begin
      if ($urandom_range(9) == 0) send_item(FUNC_QUERY, touch_coord(scr_w), touch_coord(scr_h));
      send_item(FUNC_ADVANCE, 10'($urandom), 10'($urandom));
    end
    repeat (4) send_item(FUNC_QUERY, touch_coord(scr_w), touch_coord(scr_h));
    repeat (20) send_item(FUNC_POP, 10'($urandom), 10'($urandom));

    for (int mode = 0; mode < 3; mode++) begin
      drain();
      snd_idle = (mode == 0) ? 29 : ((mode == 1) ? 77 : 0);
      rcv_idle = (mode == 0) ? 77 : ((mode == 1) ? 29 : 0);
      configure(pick_size(), pick_size(), pick_byte(), pick_byte(), pick_byte());
      repeat (3) run_spiral($urandom_range(5, 30));
    end

    drain();
    repeat (300) @(negedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
